// File: rtl/core/jsd_pkg.sv
// ----------------------------------------------------------------------------
// jsd_pkg
// shared constants and types for the deadline scheduler
// ----------------------------------------------------------------------------
package jsd_pkg;

    localparam int MAX_JOBS    = 1024;
    localparam int PROFIT_BITS = 16;
    localparam int DL_W        = $clog2(MAX_JOBS + 1);
    localparam int KEY_W       = (DL_W > PROFIT_BITS) ? DL_W : PROFIT_BITS;
    localparam int DONE_W      = 11;
    localparam int TOTAL_W     = 26;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } chain_ctrl_t;

    typedef struct packed {
        logic                   valid;
        logic [KEY_W-1:0]       key;
        logic [PROFIT_BITS-1:0] pay;
    } entry_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCHED,
        S_OUT
    } state_t;

endpackage

// File: rtl/core/jsd_cell.sv
// ----------------------------------------------------------------------------
// jsd_cell
// one entry of a descending sorted insertion chain
// ----------------------------------------------------------------------------
module jsd_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jsd_pkg::chain_ctrl_t  ctrl,
    input  jsd_pkg::entry_t       new_entry,
    input  jsd_pkg::entry_t       prev_entry,
    input  logic                  prev_lt,
    input  jsd_pkg::entry_t       next_entry,
    output jsd_pkg::entry_t       cur_entry,
    output logic                  cur_lt
);
    import jsd_pkg::*;

    logic                   valid_reg, valid_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [PROFIT_BITS-1:0] pay_reg, pay_next;

    // empty or smaller than the incoming key
    assign cur_lt = !valid_reg || (key_reg < new_entry.key);

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        if (ctrl.clr) begin
            valid_next = 1'b0;
        end else if (ctrl.pop) begin
            valid_next = next_entry.valid;
            key_next   = next_entry.key;
            pay_next   = next_entry.pay;
        end else if (ctrl.ins) begin
            if (prev_lt) begin
                valid_next = prev_entry.valid;
                key_next   = prev_entry.key;
                pay_next   = prev_entry.pay;
            end else if (cur_lt) begin
                valid_next = 1'b1;
                key_next   = new_entry.key;
                pay_next   = new_entry.pay;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign cur_entry = '{valid: valid_reg, key: key_reg, pay: pay_reg};

endmodule

// File: rtl/core/jsd_chain.sv
// ----------------------------------------------------------------------------
// jsd_chain
// row of cells kept in descending key order, insert anywhere, pop at head
// ----------------------------------------------------------------------------
module jsd_chain (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  jsd_pkg::chain_ctrl_t  ctrl,
    input  jsd_pkg::entry_t       new_entry,
    output jsd_pkg::entry_t       head
);
    import jsd_pkg::*;

    entry_t cells [MAX_JOBS];
    logic   lts   [MAX_JOBS];

    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
        entry_t prev_e, next_e;
        logic   prev_l;

        if (i == 0) begin : g_first
            // nothing above the head shifts down into it
            assign prev_e = new_entry;
            assign prev_l = 1'b0;
        end else begin : g_mid
            assign prev_e = cells[i-1];
            assign prev_l = lts[i-1];
        end

        if (i == MAX_JOBS - 1) begin : g_last
            assign next_e = '0;
        end else begin : g_body
            assign next_e = cells[i+1];
        end

        jsd_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_lt    (prev_l),
            .next_entry (next_e),
            .cur_entry  (cells[i]),
            .cur_lt     (lts[i])
        );
    end

    assign head = cells[0];

endmodule

// File: rtl/core/job_sequencing_deadline_scheduler.sv
// ----------------------------------------------------------------------------
// job_sequencing_deadline_scheduler
// greedy unit-time job scheduler with deadlines, built on two sorted chains
// ----------------------------------------------------------------------------
// loading: one item per cycle; up to MAX_JOBS inserted, the rest set overflow
// scheduling: after the last item, for each day from MAX_JOBS down to 1,
//   jobs with a non-zero deadline due that day move to the profit chain,
//   then the day goes to the best waiting job; input is stalled throughout
// result: held until taken, then both chains clear
// reset: synchronous active-low aresetn empties both chains and the counters
// ----------------------------------------------------------------------------
module job_sequencing_deadline_scheduler (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [10:0]                  s_job_deadline,
    input  logic [15:0]                  s_job_profit,
    input  logic                         s_last_job,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [10:0]                  m_jobs_done,
    output logic [25:0]                  m_profit_total,
    output logic                         m_overflow
);
    import jsd_pkg::*;

    // the schedule is built backwards in time: for each day from the last
    // one down, move jobs with that deadline into a profit ordered chain,
    // then give the day to the most profitable waiting job. this yields
    // the same count and total as the latest-free-slot greedy

    state_t state_reg, state_next;

    logic [DL_W-1:0]    loaded_reg, loaded_next;
    logic               drop_reg, drop_next;
    logic [DL_W-1:0]    day_reg, day_next;
    logic [DONE_W-1:0]  done_reg, done_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    chain_ctrl_t dl_ctrl, pr_ctrl;
    entry_t      dl_new, pr_new, dl_head, pr_head;

    logic            in_acc;
    logic [DL_W-1:0] dl_clamped;
    logic            dl_hit;

    assign in_acc = s_valid && s_ready;

    // deadlines beyond the set size give the same result when clamped
    assign dl_clamped = (s_job_deadline > DL_W'(MAX_JOBS)) ? DL_W'(MAX_JOBS)
                                                           : DL_W'(s_job_deadline);

    // head of the deadline chain is due on the current day
    assign dl_hit = dl_head.valid && (dl_head.key == KEY_W'(day_reg));

    assign dl_new = '{valid: 1'b1, key: KEY_W'(dl_clamped),
                      pay: PROFIT_BITS'(s_job_profit)};
    assign pr_new = '{valid: 1'b1, key: KEY_W'(dl_head.pay), pay: dl_head.pay};

    jsd_chain u_dl_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (dl_ctrl),
        .new_entry (dl_new),
        .head      (dl_head)
    );

    jsd_chain u_pr_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (pr_ctrl),
        .new_entry (pr_new),
        .head      (pr_head)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (in_acc && s_last_job) begin
                    state_next = S_SCHED;
                end
            end
            S_SCHED: begin
                if (day_reg == '0) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_LOAD;
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // datapath and chain control
    always_comb begin
        loaded_next = loaded_reg;
        drop_next   = drop_reg;
        day_next    = day_reg;
        done_next   = done_reg;
        total_next  = total_reg;
        dl_ctrl     = '0;
        pr_ctrl     = '0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                s_ready = 1'b1;
                if (in_acc) begin
                    if (loaded_reg < DL_W'(MAX_JOBS)) begin
                        dl_ctrl.ins = 1'b1;
                        loaded_next = loaded_reg + 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_last_job) begin
                        day_next   = DL_W'(MAX_JOBS);
                        done_next  = '0;
                        total_next = '0;
                    end
                end
            end
            S_SCHED: begin
                if (day_reg != '0) begin
                    if (dl_hit) begin
                        dl_ctrl.pop = 1'b1;
                        pr_ctrl.ins = 1'b1;
                    end else begin
                        if (pr_head.valid) begin
                            pr_ctrl.pop = 1'b1;
                            done_next   = done_reg + 1'b1;
                            total_next  = total_reg + TOTAL_W'(pr_head.pay);
                        end
                        day_next = day_reg - 1'b1;
                    end
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    dl_ctrl.clr = 1'b1;
                    pr_ctrl.clr = 1'b1;
                    loaded_next = '0;
                    drop_next   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            loaded_reg <= '0;
            drop_reg   <= 1'b0;
            day_reg    <= '0;
            done_reg   <= '0;
            total_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            drop_reg   <= drop_next;
            day_reg    <= day_next;
            done_reg   <= done_next;
            total_reg  <= total_next;
        end
    end

    assign m_jobs_done    = done_reg;
    assign m_profit_total = total_reg;
    assign m_overflow     = drop_reg;

    // deadline chain head never lies beyond the current day while scheduling
    a_head_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCHED && dl_head.valid) |-> (dl_head.key <= KEY_W'(day_reg)))
        else $error("deadline chain head beyond current day");

    // no more jobs scheduled than were loaded
    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (DL_W'(done_reg) <= loaded_reg))
        else $error("scheduled count exceeds loaded jobs");

    // the two sides never handshake together
    a_side_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides active together");

    // chains are empty after a result is taken
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (!dl_head.valid && !pr_head.valid))
        else $error("chains not cleared after result");

endmodule
